// File: design/sem_pkg.sv
package sem_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int HEIGHT_CAP    = 8190;

   localparam int FW_W   = 11;
   localparam int FH_W   = 13;
   localparam int CSR_W  = 13;
   localparam int CSR_IX_W = 1;

   localparam logic [CSR_IX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // luma weights, per mille
   localparam logic [9:0] WEIGHT_R = 10'd299;
   localparam logic [9:0] WEIGHT_G = 10'd587;
   localparam logic [9:0] WEIGHT_B = 10'd114;
   localparam logic [9:0] LUMA_DIV = 10'd1000;
   // ceil(2^20 / 1000): quotient is exact or one too high below 256000
   localparam logic [10:0] LUMA_RECIP = 11'd1049;
   localparam int          RECIP_SHIFT = 20;

   localparam logic [7:0] PIX_MAX = 8'd255;

   typedef struct packed {
      logic       func;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] edge_value;
      logic       frame_end;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_RECIP,
      ST_GRAY,
      ST_GRAD,
      ST_SQUARE,
      ST_MAG,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic recip_en;
      logic gray_en;
      logic grad_en;
      logic sq_en;
      logic mag_en;
      logic root_en;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic root_last;
      logic out_free;
      logic has_result;
   } status_type;

endpackage

// File: design/sem_ram.sv
module sem_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = sem_pkg::MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/sem_ctrl.sv
module sem_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sem_pkg::status_type  status,
   output sem_pkg::cmd_type     cmd
);

   sem_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sem_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sem_pkg::ST_IDLE:   if (req_valid) state_in = sem_pkg::ST_SUM;
         sem_pkg::ST_SUM:    state_in = sem_pkg::ST_RECIP;
         sem_pkg::ST_RECIP:  state_in = sem_pkg::ST_GRAY;
         sem_pkg::ST_GRAY:   state_in = sem_pkg::ST_GRAD;
         sem_pkg::ST_GRAD:   state_in = sem_pkg::ST_SQUARE;
         sem_pkg::ST_SQUARE: state_in = sem_pkg::ST_MAG;
         sem_pkg::ST_MAG:    state_in = sem_pkg::ST_ROOT;
         sem_pkg::ST_ROOT:   if (status.root_last) state_in = sem_pkg::ST_EMIT;
         sem_pkg::ST_EMIT: begin
            if (!status.has_result || status.out_free) begin
               state_in = sem_pkg::ST_IDLE;
            end
         end
         default:            state_in = sem_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         sem_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         sem_pkg::ST_SUM:    cmd.rd_en    = 1'b1;
         sem_pkg::ST_RECIP:  cmd.recip_en = 1'b1;
         sem_pkg::ST_GRAY:   cmd.gray_en  = 1'b1;
         sem_pkg::ST_GRAD:   cmd.grad_en  = 1'b1;
         sem_pkg::ST_SQUARE: cmd.sq_en    = 1'b1;
         sem_pkg::ST_MAG:    cmd.mag_en   = 1'b1;
         sem_pkg::ST_ROOT:   cmd.root_en  = 1'b1;
         sem_pkg::ST_EMIT:   cmd.out_load = status.has_result && status.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: design/sem_datapath.sv
module sem_datapath #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sem_pkg::req_type              req_data,
   output sem_pkg::rsp_type              rsp_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          csr_wr_en,
   input  logic [sem_pkg::CSR_IX_W-1:0]  csr_index,
   input  logic [sem_pkg::CSR_W-1:0]     csr_wdata,
   input  sem_pkg::cmd_type              cmd,
   output sem_pkg::status_type           status
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int WW     = $clog2(MAX_WIDTH + 1);

   // configuration
   logic [sem_pkg::FW_W-1:0] fw_ff;
   logic [sem_pkg::FH_W-1:0] fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= sem_pkg::FW_W'(1);
         fh_ff <= sem_pkg::FH_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            sem_pkg::CSR_FRAME_WIDTH:  fw_ff <= csr_wdata[sem_pkg::FW_W-1:0];
            sem_pkg::CSR_FRAME_HEIGHT: fh_ff <= csr_wdata[sem_pkg::FH_W-1:0];
            default: ;
         endcase
      end
   end

   // effective sizes
   logic [13:0] w_wide;
   logic [WW-1:0] w_eff;
   logic [sem_pkg::FH_W-1:0] h_eff;

   always_comb begin
      if (fw_ff == '0) begin
         w_wide = 14'd1;
      end else if ({3'b0, fw_ff} > 14'(MAX_WIDTH)) begin
         w_wide = 14'(MAX_WIDTH);
      end else begin
         w_wide = {3'b0, fw_ff};
      end
      w_eff = WW'(w_wide);
      if (fh_ff == '0) begin
         h_eff = sem_pkg::FH_W'(1);
      end else if (32'(fh_ff) > sem_pkg::HEIGHT_CAP) begin
         h_eff = sem_pkg::FH_W'(sem_pkg::HEIGHT_CAP);
      end else begin
         h_eff = fh_ff;
      end
   end

   // position of the incoming request
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [sem_pkg::FH_W-1:0] row_ff, row_in;
   logic [ADDR_W-1:0] cx;
   logic [sem_pkg::FH_W-1:0] cy;
   logic [13:0] h_plus1;
   logic [WW-1:0] cx_next, ox;
   logic signed [14:0] oy;
   logic last_c, emit_c, inner_c;

   always_comb begin
      h_plus1 = {1'b0, h_eff} + 14'd1;
      cx = col_ff;
      cy = row_ff;
      if (WW'(col_ff) >= w_eff) begin
         cx = '0;
      end
      if ({1'b0, row_ff} > h_plus1) begin
         cx = '0;
         cy = '0;
      end
      cx_next = WW'(cx) + WW'(1);
      last_c  = (cx == '0) && ({1'b0, cy} == h_plus1);
      if (cx_next >= w_eff) begin
         col_in = '0;
         row_in = cy + sem_pkg::FH_W'(1);
      end else begin
         col_in = ADDR_W'(cx_next);
         row_in = cy;
      end
      if (last_c) begin
         col_in = '0;
         row_in = '0;
      end
      if (cx != '0) begin
         ox = WW'(cx) - WW'(1);
         oy = $signed({2'b0, cy}) - 15'sd1;
      end else begin
         ox = w_eff - WW'(1);
         oy = $signed({2'b0, cy}) - 15'sd2;
      end
      emit_c  = (oy >= 15'sd0);
      inner_c = (ox != '0) && ({1'b0, ox} + (WW+1)'(2) <= {1'b0, w_eff})
                && (oy >= 15'sd1) && (oy + 15'sd2 <= $signed({2'b0, h_eff}));
   end

   logic [ADDR_W-1:0] cx_ff;
   logic last_ff, emit_ff, inner_ff;
   sem_pkg::req_type pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.load) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff    <= cx;
         last_ff  <= last_c;
         emit_ff  <= emit_c;
         inner_ff <= inner_c;
         pix_ff   <= req_data;
      end
   end

   // luma
   logic [17:0] sum_ff;
   logic [28:0] prod_ff;
   logic [7:0]  up_ff, mid_ff;
   logic [7:0]  up_rd, mid_rd;
   logic [8:0]  q_raw;
   logic [7:0]  gray_c;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         if (pix_ff.func) begin
            sum_ff <= '0;
         end else begin
            sum_ff <= 18'(pix_ff.red * sem_pkg::WEIGHT_R)
                    + 18'(pix_ff.green * sem_pkg::WEIGHT_G)
                    + 18'(pix_ff.blue * sem_pkg::WEIGHT_B);
         end
      end
      if (cmd.recip_en) begin
         prod_ff <= 29'(sum_ff * sem_pkg::LUMA_RECIP);
         up_ff   <= up_rd;
         mid_ff  <= mid_rd;
      end
   end

   always_comb begin
      q_raw = prod_ff[sem_pkg::RECIP_SHIFT +: 9];
      if (19'(q_raw * sem_pkg::LUMA_DIV) > {1'b0, sum_ff}) begin
         gray_c = 8'(q_raw - 9'd1);
      end else begin
         gray_c = q_raw[7:0];
      end
   end

   sem_ram #(.DATA_W(8), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (cmd.gray_en),
      .wr_addr (cx_ff),
      .wr_data (mid_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (cx_ff),
      .rd_data (up_rd)
   );

   sem_ram #(.DATA_W(8), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (cmd.gray_en),
      .wr_addr (cx_ff),
      .wr_data (gray_c),
      .rd_en   (cmd.rd_en),
      .rd_addr (cx_ff),
      .rd_data (mid_rd)
   );

   // 3x3 window, right column takes the new samples
   logic [7:0] win_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.gray_en) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[2] <= up_ff;
         win_ff[5] <= mid_ff;
         win_ff[8] <= gray_c;
      end
   end

   // gradients and magnitude
   logic signed [10:0] gx_ff, gy_ff;
   logic [20:0] sqx_ff, sqy_ff;
   logic [21:0] mag_ff;
   logic [7:0]  root_ff, bit_ff;
   logic [9:0]  gxp, gxn, gyp, gyn;
   logic [7:0]  trial;

   always_comb begin
      gxp = 10'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + 10'(win_ff[8]);
      gxn = 10'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + 10'(win_ff[6]);
      gyp = 10'(win_ff[6]) + {1'b0, win_ff[7], 1'b0} + 10'(win_ff[8]);
      gyn = 10'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + 10'(win_ff[2]);
      trial = root_ff | bit_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.grad_en) begin
         gx_ff <= $signed({1'b0, gxp}) - $signed({1'b0, gxn});
         gy_ff <= $signed({1'b0, gyp}) - $signed({1'b0, gyn});
      end
      if (cmd.sq_en) begin
         sqx_ff <= 21'(gx_ff * gx_ff);
         sqy_ff <= 21'(gy_ff * gy_ff);
      end
      if (cmd.mag_en) begin
         mag_ff  <= 22'(sqx_ff) + 22'(sqy_ff);
         root_ff <= '0;
         bit_ff  <= 8'h80;
      end
      if (cmd.root_en) begin
         if (16'(trial * trial) <= mag_ff[15:0]) begin
            root_ff <= trial;
         end
         bit_ff <= bit_ff >> 1;
      end
   end

   // output register
   logic rsp_valid_ff;
   sem_pkg::rsp_type rsp_ff;
   logic sat;
   logic [7:0] mag_clamped;

   assign sat         = |mag_ff[21:16];
   assign mag_clamped = sat ? sem_pkg::PIX_MAX : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.edge_value <= inner_ff ? sem_pkg::PIX_MAX - mag_clamped
                                       : sem_pkg::PIX_MAX - win_ff[4];
         rsp_ff.frame_end  <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_ff;
   assign status.root_last  = (bit_ff == 8'h01);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.has_result = emit_ff;

   a_gray_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.gray_en |-> (18'(gray_c * sem_pkg::LUMA_DIV) <= sum_ff)
                      && (19'((gray_c + 9'd1) * sem_pkg::LUMA_DIV) > {1'b0, sum_ff}))
      else $error("luma quotient off by one");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && !sat) |-> (16'(root_ff * root_ff) <= mag_ff[15:0]))
      else $error("square root too large");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("response raised without a load");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && rsp_valid_ff) |-> rsp_ready)
      else $error("response overwritten before it was taken");

endmodule

// File: design/sobel_edge_magnitude.sv
// One request at a time: the next is accepted only once the last has left
//   emit, which waits while a response is held; the 8-step bit-serial square root and the luma divide set the pace.
// Reset (synchronous, active high): frame size 1x1, position and 3x3 window
//   cleared, no response pending. Line stores are not cleared and need no pass.
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // pixel requests
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sem_pkg::req_type              req_data,
   // edge responses
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sem_pkg::rsp_type              rsp_data,
   // register writes
   input  logic                          csr_wr_en,
   input  logic [sem_pkg::CSR_IX_W-1:0]  csr_index,
   input  logic [sem_pkg::CSR_W-1:0]     csr_wdata
);

   // Controller steps one request through: accept, luma sum, reciprocal
   // multiply, luma correct plus line store update and window shift,
   // gradients, squares, magnitude, eight root steps, emit.
   sem_pkg::cmd_type    cmd;
   sem_pkg::status_type status;

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: position counters, two line stores, window, Sobel arithmetic
   // and the response register. A request at column 0 of the drain row
   // carries the frame end flag; positions before the frame start give none.
   sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// File: verif/tb_sobel_edge_magnitude.sv
module tb_sobel_edge_magnitude;

   // predicts the inverted Sobel magnitude stream and holds the edge values still owed
   class edge_scoreboard;
      logic [sem_pkg::FW_W-1:0] width_reg;
      logic [sem_pkg::FH_W-1:0] height_reg;
      logic [7:0]      upper_row [sem_pkg::MAX_WIDTH_DEF];
      logic [7:0]      middle_row [sem_pkg::MAX_WIDTH_DEF];
      logic [7:0]      win [9];
      int              col;
      int              row;
      sem_pkg::rsp_type owed_edges [$];
      int              errors;

      function void clear();
         width_reg  = 1;
         height_reg = 1;
         foreach (win[i]) win[i] = 8'd0;
         col = 0;
         row = 0;
         owed_edges.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [sem_pkg::CSR_IX_W-1:0] ix,
                              logic [sem_pkg::CSR_W-1:0] data);
         if (ix == sem_pkg::CSR_FRAME_WIDTH)
            width_reg = data[sem_pkg::FW_W-1:0];
         else
            height_reg = data[sem_pkg::FH_W-1:0];
      endfunction

      function int root8(int s);
         int r;
         r = 0;
         for (int b = 128; b != 0; b = b >> 1)
            if ((r + b) * (r + b) <= s)
               r = r + b;
         return r;
      endfunction

      function void note_request(sem_pkg::req_type rq);
         int w, h, cx, cy, ox, oy, gray, gx, gy, s, mag;
         logic [7:0] up, mid;
         bit last;
         sem_pkg::rsp_type rs;
         w = width_reg;
         h = height_reg;
         if (w < 1) w = 1;
         if (w > sem_pkg::MAX_WIDTH_DEF) w = sem_pkg::MAX_WIDTH_DEF;
         if (h < 1) h = 1;
         if (h > sem_pkg::HEIGHT_CAP) h = sem_pkg::HEIGHT_CAP;
         if (col >= w) col = 0;
         if (row > h + 1) begin
            row = 0;
            col = 0;
         end
         cx = col;
         cy = row;
         gray = 0;
         if (rq.func == 1'b0)
            gray = (299 * rq.red + 587 * rq.green + 114 * rq.blue) / 1000;
         up  = upper_row[cx];
         mid = middle_row[cx];
         win[0] = win[1]; win[1] = win[2];
         win[3] = win[4]; win[4] = win[5];
         win[6] = win[7]; win[7] = win[8];
         win[2] = up;
         win[5] = mid;
         win[8] = gray[7:0];
         upper_row[cx]  = mid;
         middle_row[cx] = gray[7:0];
         if (cx >= 1) begin
            ox = cx - 1;
            oy = cy - 1;
         end else begin
            ox = w - 1;
            oy = cy - 2;
         end
         last = (cx == 0 && cy == h + 1);
         if (cx + 1 >= w) begin
            col = 0;
            row = cy + 1;
         end else begin
            col = cx + 1;
         end
         if (last) begin
            col = 0;
            row = 0;
         end
         if (oy < 0)
            return;
         if (ox >= 1 && ox <= w - 2 && oy >= 1 && oy <= h - 2) begin
            gx = (win[2] + 2 * win[5] + win[8]) - (win[0] + 2 * win[3] + win[6]);
            gy = (win[6] + 2 * win[7] + win[8]) - (win[0] + 2 * win[1] + win[2]);
            s = gx * gx + gy * gy;
            mag = (s >= 65536) ? 255 : root8(s);
            rs.edge_value = 8'(255 - mag);
         end else begin
            rs.edge_value = 8'(255 - win[4]);
         end
         rs.frame_end = last;
         owed_edges.push_back(rs);
      endfunction

      function void check_response(sem_pkg::rsp_type got);
         sem_pkg::rsp_type want;
         if (owed_edges.size() == 0) begin
            $display("%0t: unexpected response, got edge %0d end %0b",
                     $time, got.edge_value, got.frame_end);
            errors++;
            return;
         end
         want = owed_edges.pop_front();
         if (got.edge_value !== want.edge_value) begin
            $display("%0t: edge_value expected %0d, got %0d",
                     $time, want.edge_value, got.edge_value);
            errors++;
         end
         if (got.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b, got %0b",
                     $time, want.frame_end, got.frame_end);
            errors++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   sem_pkg::req_type             req_data = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   sem_pkg::rsp_type             rsp_data;
   logic                         csr_wr_en = 1'b0;
   logic [sem_pkg::CSR_IX_W-1:0] csr_index = sem_pkg::CSR_FRAME_WIDTH;
   logic [sem_pkg::CSR_W-1:0]    csr_wdata = '0;

   edge_scoreboard sb = new();
   bit  calm;             // when set neither side idles
   int  requests_sent;
   int  quiet_cycles = 0;

   localparam int QUIET_LIMIT = 3000;
   localparam int DRAIN_WAIT  = 40;   // leave ample margin for the core to settle

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sobel_edge_magnitude dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // watchdog: a stretch longer than QUIET_LIMIT with no request, response or register write taken ends the run
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side: random stalls per response, none while calm
   initial begin : rsp_side
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         sb.check_response(rsp_data);
      end
   end

   task automatic send_request(sem_pkg::req_type rq);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_request(rq);
      requests_sent++;
   endtask

   // block the sender until every owed edge value is back, then let the core settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.owed_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_size(logic [sem_pkg::CSR_W-1:0] w, logic [sem_pkg::CSR_W-1:0] h);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= sem_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      sb.write_reg(sem_pkg::CSR_FRAME_WIDTH, w);
      csr_index <= sem_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      sb.write_reg(sem_pkg::CSR_FRAME_HEIGHT, h);
      csr_wr_en <= 1'b0;
   endtask

   // one whole frame plus its drain tail; style 0 random, 1 black/white, 2 gentle ramp
   task automatic run_frame(int w, int h, int style);
      sem_pkg::req_type rq;
      int      v;
      for (int y = 0; y < h + 2; y++)
         for (int x = 0; x < w; x++) begin
            if (y == h + 1 && x > 0)
               break;
            rq.red   = 8'($urandom_range(0, 255));
            rq.green = 8'($urandom_range(0, 255));
            rq.blue  = 8'($urandom_range(0, 255));
            if (style == 1) begin
               v = ($urandom_range(0, 1) != 0) ? 255 : 0;
               rq.red = 8'(v); rq.green = 8'(v); rq.blue = 8'(v);
            end else if (style == 2) begin
               v = (x * 7 + y * 5) & 8'hff;
               rq.red = 8'(v); rq.green = 8'(v); rq.blue = 8'(v);
            end
            if (y < h)
               rq.func = ($urandom_range(0, 19) == 0);  // odd drain inside the frame
            else
               rq.func = ($urandom_range(0, 3) != 0);   // odd pixel in drain slots
            send_request(rq);
         end
   endtask

   initial begin : stimulus
      sem_pkg::req_type rq;
      int w, h;
      sb.clear();
      calm = 1'b0;
      requests_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default 1x1 frame, white then black, then corner colours
      rq = '{func: 1'b0, red: 8'hff, green: 8'hff, blue: 8'hff};
      send_request(rq);
      rq.func = 1'b1;
      send_request(rq);
      send_request(rq);
      rq = '{func: 1'b0, red: 8'h00, green: 8'h00, blue: 8'h00};
      send_request(rq);
      rq.func = 1'b1;
      send_request(rq);
      rq = '{func: 1'b0, red: 8'hff, green: 8'h00, blue: 8'h00};
      send_request(rq);
      // start a frame with the next and send one more row of it
      rq = '{func: 1'b0, red: 8'h00, green: 8'hff, blue: 8'h00};
      send_request(rq);
      rq = '{func: 1'b0, red: 8'h00, green: 8'h00, blue: 8'hff};
      send_request(rq);

      // width written with bits above its field set: only 5 should take
      set_size(13'h1805, 13'd4);
      run_frame(5, 4, 1);

      // range edges: zero sizes, then a one pixel wide frame
      set_size(13'd0, 13'd0);
      run_frame(1, 1, 0);
      set_size(13'd1, 13'd2);
      run_frame(1, 2, 0);
      set_size(13'd12, 13'd6);
      calm = 1'b1;
      run_frame(12, 6, 2);
      calm = 1'b0;

      // random frames, mostly small
      while (requests_sent < 1650) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
         h = $urandom_range(1, 10);
         set_size(sem_pkg::CSR_W'(w), sem_pkg::CSR_W'(h));
         calm = ($urandom_range(0, 4) == 0);
         run_frame(w, h, $urandom_range(0, 2));
      end

      calm = 1'b0;
      wait_idle();
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
